// ===== src/lfu_pkg.sv =====
// Package for the LFU cache table: widths, defaults, register map,
// controller state codes and the controller/datapath command and status types.
// No dependencies.
package lfu_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 5;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CFG_W-1:0]  CAP_RESET  = CFG_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOKUP = 7'b0000010,
        ST_TOUCH  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_EVICT  = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic lookup;
        logic touch;
        logic scan_clr;
        logic scan_step;
        logic evict;
        logic insert;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic is_put;
        logic cap_zero;
        logic full;
        logic scan_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== src/lfu_req_if.sv =====
// Request channel of the LFU cache table: valid/ready plus the request beat.
// Depends on lfu_pkg.
interface lfu_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [lfu_pkg::DATA_W-1:0] lookup_key;
    logic [lfu_pkg::DATA_W-1:0] put_value;

    modport source (output valid, opcode, lookup_key, put_value, input ready);
    modport sink   (input valid, opcode, lookup_key, put_value, output ready);
endinterface

// ===== src/lfu_rsp_if.sv =====
// Response channel of the LFU cache table: valid/ready plus the response beat.
// Depends on lfu_pkg.
interface lfu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lfu_pkg::DATA_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

// ===== src/lfu_ctrl.sv =====
// Controller state machine of the LFU cache table.
// Depends on lfu_pkg (state_t, cmd_t, sts_t).
module lfu_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lfu_pkg::sts_t  sts,
    output lfu_pkg::cmd_t  cmd
);

    lfu_pkg::state_t state_reg;
    lfu_pkg::state_t state_next;

    assign req_ready = (state_reg == lfu_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = lfu_pkg::ST_LOOKUP;
                end
            end
            lfu_pkg::ST_LOOKUP:
            begin
                cmd.lookup   = 1'b1;
                cmd.scan_clr = 1'b1;
                priority if (sts.cap_zero)
                    state_next = lfu_pkg::ST_RESP;
                else if (sts.match)
                    state_next = lfu_pkg::ST_TOUCH;
                else if (!sts.is_put)
                    state_next = lfu_pkg::ST_RESP;
                else if (sts.full)
                    state_next = lfu_pkg::ST_SCAN;
                else
                    state_next = lfu_pkg::ST_INSERT;
            end
            lfu_pkg::ST_TOUCH:
            begin
                cmd.touch  = 1'b1;
                state_next = lfu_pkg::ST_RESP;
            end
            lfu_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = lfu_pkg::ST_EVICT;
            end
            lfu_pkg::ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = lfu_pkg::ST_INSERT;
            end
            lfu_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = lfu_pkg::ST_RESP;
            end
            lfu_pkg::ST_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lfu_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/lfu_dp.sv =====
// Datapath of the LFU cache table: entry lanes, key match, victim scan,
// rank bookkeeping and the response register. Depends on lfu_pkg.
module lfu_dp
#(
    parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfu_pkg::cmd_t              cmd,
    output lfu_pkg::sts_t              sts,
    input  logic [lfu_pkg::CFG_W-1:0]  capacity_in_use,
    input  logic                       in_opcode,
    input  logic [lfu_pkg::DATA_W-1:0] in_key,
    input  logic [lfu_pkg::DATA_W-1:0] in_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_hit,
    output logic [lfu_pkg::DATA_W-1:0] out_value
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(CAPACITY - 1);

    // entry lanes
    logic                       valid_reg [CAPACITY];
    logic [lfu_pkg::DATA_W-1:0] key_reg   [CAPACITY];
    logic [lfu_pkg::DATA_W-1:0] value_reg [CAPACITY];
    logic [COUNT_WIDTH-1:0]     count_reg [CAPACITY];
    logic [IDX_W-1:0]           rank_reg  [CAPACITY];
    logic [OCC_W-1:0]           occ_reg;

    // current item
    logic                       op_reg;
    logic [lfu_pkg::DATA_W-1:0] key_in_reg;
    logic [lfu_pkg::DATA_W-1:0] val_in_reg;

    logic                       hit_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic                       res_hit_reg;
    logic [lfu_pkg::DATA_W-1:0] res_value_reg;

    logic                       vic_valid_reg;
    logic [IDX_W-1:0]           vic_idx_reg;
    logic [IDX_W-1:0]           scan_idx_reg;

    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [lfu_pkg::DATA_W-1:0] out_value_reg;

    logic                       match_any;
    logic [IDX_W-1:0]           match_idx;
    logic                       free_any;
    logic [IDX_W-1:0]           free_idx;
    logic [CMP_W-1:0]           cap_eff;
    logic                       take_scan;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == key_in_reg)
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // register saturates at the configured table size
    always_comb
    begin
        if (CMP_W'(capacity_in_use) > CMP_W'(CAPACITY))
            cap_eff = CMP_W'(CAPACITY);
        else
            cap_eff = CMP_W'(capacity_in_use);
    end

    // lowest count wins, ties to the least recent (highest rank)
    always_comb
    begin
        take_scan = 1'b0;
        if (valid_reg[scan_idx_reg])
        begin
            if (!vic_valid_reg)
                take_scan = 1'b1;
            else if (count_reg[scan_idx_reg] < count_reg[vic_idx_reg])
                take_scan = 1'b1;
            else if (count_reg[scan_idx_reg] == count_reg[vic_idx_reg]
                     && rank_reg[scan_idx_reg] > rank_reg[vic_idx_reg])
                take_scan = 1'b1;
        end
    end

    always_comb
    begin
        sts.match     = match_any;
        sts.is_put    = (op_reg == lfu_pkg::OP_PUT);
        sts.cap_zero  = (cap_eff == '0);
        sts.full      = (CMP_W'(occ_reg) >= cap_eff);
        sts.scan_last = (scan_idx_reg == LAST_IDX);
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                valid_reg[i] <= 1'b0;
            occ_reg       <= '0;
            vic_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                vic_valid_reg <= 1'b0;
                scan_idx_reg  <= '0;
            end
            if (cmd.scan_step)
            begin
                if (take_scan)
                    vic_valid_reg <= 1'b1;
                if (scan_idx_reg != LAST_IDX)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (cmd.evict && vic_valid_reg)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                occ_reg                <= occ_reg - 1'b1;
            end
            if (cmd.insert && free_any)
            begin
                valid_reg[free_idx] <= 1'b1;
                occ_reg             <= occ_reg + 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_opcode;
            key_in_reg <= in_key;
            val_in_reg <= in_value;
        end
        if (cmd.lookup)
        begin
            hit_reg     <= match_any;
            hit_idx_reg <= match_idx;
            res_hit_reg <= match_any && (cap_eff != '0);
            if (op_reg == lfu_pkg::OP_PUT)
                res_value_reg <= val_in_reg;
            else if (match_any && cap_eff != '0)
                res_value_reg <= value_reg[match_idx];
            else
                res_value_reg <= lfu_pkg::MISS_VALUE;
        end
        if (cmd.scan_step && take_scan)
            vic_idx_reg <= scan_idx_reg;
        if (cmd.touch && hit_reg)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (valid_reg[i] && rank_reg[i] < rank_reg[hit_idx_reg])
                    rank_reg[i] <= rank_reg[i] + 1'b1;
            rank_reg[hit_idx_reg] <= '0;
            if (count_reg[hit_idx_reg] != COUNT_MAX)
                count_reg[hit_idx_reg] <= count_reg[hit_idx_reg] + 1'b1;
            if (op_reg == lfu_pkg::OP_PUT)
                value_reg[hit_idx_reg] <= val_in_reg;
        end
        if (cmd.evict && vic_valid_reg)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (valid_reg[i] && rank_reg[i] > rank_reg[vic_idx_reg])
                    rank_reg[i] <= rank_reg[i] - 1'b1;
        end
        if (cmd.insert && free_any)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (valid_reg[i])
                    rank_reg[i] <= rank_reg[i] + 1'b1;
            key_reg[free_idx]   <= key_in_reg;
            value_reg[free_idx] <= val_in_reg;
            count_reg[free_idx] <= COUNT_WIDTH'(1);
            rank_reg[free_idx]  <= '0;
        end
        if (cmd.load_out)
        begin
            out_hit_reg   <= res_hit_reg;
            out_value_reg <= res_value_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

endmodule

// ===== src/lfu_cache_table.sv =====
// LFU cache table, top level: APB capacity register, controller, datapath.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_ctrl, lfu_dp.
//
// Fully associative key/value store with least-frequently-used replacement,
// ties broken by least recent access. Requests come in one beat at a time on
// req (get or put); each produces exactly one response beat on rsp. A get or
// put hit steps through accept, parallel key compare, touch and response
// load; a get miss skips the touch. A put miss into a free slot inserts in
// place of the touch; a put miss with the table full first runs the victim
// scan, which walks the entry lanes one per cycle, then evicts and inserts.
// The next request is accepted once the previous response is loaded into the
// output register, so a pending response only holds off new work while it is
// stuck behind a stalled rsp.ready.
// capacity_in_use lives at APB address 0 (reset 16, values above CAPACITY act
// as CAPACITY, 0 disables storing); write it only while the block is idle.
// Valid bits clear at reset; no clearing pass is needed.
module lfu_cache_table
#(
    parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    lfu_req_if.sink                     req,
    lfu_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [lfu_pkg::PDATA_W-1:0] pwdata,
    output logic [lfu_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [lfu_pkg::CFG_W-1:0] capacity_reg;
    lfu_pkg::cmd_t             cmd;
    lfu_pkg::sts_t             sts;
    logic                      cfg_hit;

    // word index sits in paddr[2]; one register
    assign cfg_hit = (paddr[2] == lfu_pkg::REG_CAPACITY);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= lfu_pkg::CAP_RESET;
        else if (psel && penable && pwrite && cfg_hit)
            capacity_reg <= pwdata[lfu_pkg::CFG_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
            prdata = lfu_pkg::PDATA_W'(capacity_reg);
    end

    lfu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lfu_dp
    #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .capacity_in_use (capacity_reg),
        .in_opcode       (req.opcode),
        .in_key          (req.lookup_key),
        .in_value        (req.put_value),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_hit         (rsp.hit),
        .out_value       (rsp.read_value)
    );

endmodule

// ===== tb/sv/tb_lfu_cache_table.sv =====
// Testbench for lfu_cache_table: directed table plus random get/put traffic,
// every response checked against a behavioral LFU/LRU predictor.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and the lfu_cache_table RTL.
`timescale 1ns / 100ps

module tb_lfu_cache_table;

    localparam int NENT      = lfu_pkg::CAPACITY_DEF;
    localparam int CNT_MAX   = (1 << lfu_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int IDLE_GAP  = 40;     // settle time before a register write
    localparam int WD_LIMIT  = 20000;  // cycles without any accepted beat
    localparam int N_RANDOM  = 1750;

    typedef struct packed {
        logic                       op;
        logic [lfu_pkg::DATA_W-1:0] key;
        logic [lfu_pkg::DATA_W-1:0] val;
    } req_beat_t;

    typedef struct packed {
        logic                       hit;
        logic [lfu_pkg::DATA_W-1:0] rdata;
    } rsp_beat_t;

    // directed row: item, optional typed-in answer
    typedef struct packed {
        req_beat_t beat;
        logic      fixed;
        rsp_beat_t answer;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [lfu_pkg::PADDR_W-1:0] paddr;
    logic [lfu_pkg::PDATA_W-1:0] pwdata, prdata;
    logic pready;

    lfu_req_if req ();
    lfu_rsp_if rsp ();

    lfu_cache_table i_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: shadow copy of the table and the capacity register
    // ---------------------------------------------------------------
    logic [lfu_pkg::CFG_W-1:0]  shadow_cap;
    logic                       tbl_valid [NENT];
    logic [lfu_pkg::DATA_W-1:0] tbl_key   [NENT];
    logic [lfu_pkg::DATA_W-1:0] tbl_val   [NENT];
    int unsigned                tbl_cnt   [NENT];
    int unsigned                tbl_rank  [NENT];
    int unsigned                tbl_occ;

    rsp_beat_t pending_rsp [$];   // expected responses, oldest first
    logic      pending_fix [$];   // 1 where a directed row typed the answer in
    rsp_beat_t pending_ans [$];

    int errors, n_sent, n_rcvd, n_hits, n_evict, n_cap_zero;
    bit stim_done, hold_off;
    int idle_cycles;

    function automatic void table_clear();
        tbl_occ = 0;
        for (int i = 0; i < NENT; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_val[i]   = '0;
            tbl_cnt[i]   = 0;
            tbl_rank[i]  = 0;
        end
    endfunction

    // compute the response for one accepted request and update the shadow
    function automatic rsp_beat_t lfu_predict(req_beat_t b);
        rsp_beat_t   r;
        int unsigned cap, rk;
        int          e, v, slot;
        r.hit   = 1'b0;
        r.rdata = (b.op == lfu_pkg::OP_PUT) ? b.val : lfu_pkg::MISS_VALUE;
        cap = (shadow_cap > NENT) ? NENT : shadow_cap;
        if (cap == 0)
        begin
            n_cap_zero++;
            return r;
        end
        e = -1;
        for (int i = 0; i < NENT; i++)
            if (e < 0 && tbl_valid[i] && tbl_key[i] == b.key)
                e = i;
        if (e >= 0)
        begin
            r.hit = 1'b1;
            if (b.op == lfu_pkg::OP_PUT) tbl_val[e] = b.val;
            else                         r.rdata = tbl_val[e];
            rk = tbl_rank[e];
            for (int i = 0; i < NENT; i++)
                if (tbl_valid[i] && tbl_rank[i] < rk) tbl_rank[i]++;
            tbl_rank[e] = 0;
            if (tbl_cnt[e] < CNT_MAX) tbl_cnt[e]++;
            return r;
        end
        if (b.op == lfu_pkg::OP_GET) return r;
        if (tbl_occ >= cap)
        begin
            // lowest count, ties to the least recent (highest rank)
            v = -1;
            for (int i = 0; i < NENT; i++)
                if (tbl_valid[i] && (v < 0 || tbl_cnt[i] < tbl_cnt[v] ||
                    (tbl_cnt[i] == tbl_cnt[v] && tbl_rank[i] > tbl_rank[v])))
                    v = i;
            if (v >= 0)
            begin
                n_evict++;
                rk = tbl_rank[v];
                tbl_valid[v] = 1'b0;
                for (int i = 0; i < NENT; i++)
                    if (tbl_valid[i] && tbl_rank[i] > rk) tbl_rank[i]--;
                if (tbl_occ > 0) tbl_occ--;
            end
        end
        slot = -1;
        for (int i = 0; i < NENT; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
        if (slot < 0) return r;
        for (int i = 0; i < NENT; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = b.key;
        tbl_val[slot]   = b.val;
        tbl_cnt[slot]   = 1;
        tbl_rank[slot]  = 0;
        tbl_occ++;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // valid stays up between beats with no gap; it drops only when a gap
    // follows, or when the sequence ends
    task automatic send_beat(req_beat_t b, logic fixed, rsp_beat_t ans);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;   // bursts with no gaps
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= b.op;
        req.lookup_key <= b.key;
        req.put_value  <= b.val;
        do @(posedge clk); while (!req.ready);
        // beat accepted at this edge
        pending_rsp.push_back(lfu_predict(b));
        pending_fix.push_back(fixed);
        pending_ans.push_back(ans);
        n_sent++;
    endtask

    task automatic apb_write(logic [lfu_pkg::PADDR_W-1:0] a,
                             logic [lfu_pkg::PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_cap = d[lfu_pkg::CFG_W-1:0];
    endtask

    // drain outstanding responses, then let the block go fully idle
    task automatic wait_quiet();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic set_capacity(int unsigned c);
        wait_quiet();
        apb_write({lfu_pkg::REG_CAPACITY, 2'b00}, lfu_pkg::PDATA_W'(c));
    endtask

    // keys drawn from a small pool so that hits and evictions are common
    function automatic logic [lfu_pkg::DATA_W-1:0] pick_key(int pool);
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h8000_0000 ^ lfu_pkg::DATA_W'($urandom_range(0, pool));
            default: return lfu_pkg::DATA_W'($urandom_range(0, pool)) * 32'h0101_0101;
        endcase
    endfunction

    task automatic random_phase(int n, int pool);
        req_beat_t b;
        for (int i = 0; i < n; i++)
        begin
            b.op  = ($urandom_range(0, 99) < 55) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
            b.key = pick_key(pool);
            b.val = $urandom();
            send_beat(b, 1'b0, '0);
        end
    endtask

    row_t rows [$];

    task automatic add_row(logic op, logic [31:0] k, logic [31:0] v,
                           logic fixed, logic h, logic [31:0] rd);
        row_t r;
        r.beat   = '{op: op, key: k, val: v};
        r.fixed  = fixed;
        r.answer = '{hit: h, rdata: rd};
        rows.push_back(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req.valid = 1'b0; req.opcode = lfu_pkg::OP_GET; req.lookup_key = '0;
        req.put_value = '0;
        errors = 0; n_sent = 0; n_rcvd = 0; n_hits = 0; n_evict = 0;
        n_cap_zero = 0; stim_done = 0;
        shadow_cap = lfu_pkg::CAP_RESET;
        table_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty-table misses, key/value extremes, hits, updates
        add_row(lfu_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678, 1, 0, lfu_pkg::MISS_VALUE);
        add_row(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,         1, 0, lfu_pkg::MISS_VALUE);
        add_row(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 32'h7FFF_FFFF);
        add_row(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'h8000_0000);
        add_row(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF);
        add_row(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0000_0000);
        add_row(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0,         1, 1, 32'h7FFF_FFFF);
        add_row(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0,         1, 1, 32'hFFFF_FFFF);
        add_row(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h5A5A_A5A5, 1, 1, 32'h5A5A_A5A5);
        add_row(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0,         1, 1, 32'h5A5A_A5A5);
        add_row(lfu_pkg::OP_GET, 32'h0000_0001, 32'h0,         1, 0, lfu_pkg::MISS_VALUE);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].answer);
        rows.delete();

        // fill past full with 20 keys: first misses into a full table evict
        for (int i = 0; i < 20; i++)
            add_row(lfu_pkg::OP_PUT, 32'h100 + i, 32'hA000_0000 + i, 0, 0, 0);
        foreach (rows[i]) send_beat(rows[i].beat, 1'b0, '0);
        rows.delete();

        // capacity zero: puts do nothing, gets miss despite stored entries
        set_capacity(0);
        add_row(lfu_pkg::OP_PUT, 32'h200, 32'h1, 1, 0, 32'h1);
        add_row(lfu_pkg::OP_GET, 32'h113, 32'h0, 1, 0, lfu_pkg::MISS_VALUE);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].answer);
        rows.delete();

        // register above CAPACITY saturates; 31 is the field's top
        set_capacity(31);
        random_phase(300, 24);

        // lowered below occupancy: a put miss evicts one entry and inserts one, so occupancy does not shrink
        set_capacity(1);
        random_phase(250, 6);
        set_capacity(3);
        random_phase(250, 8);

        // long response stall while requests keep coming
        set_capacity(16);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                random_phase(40, 30);
                req.valid <= 1'b0;
            end
        join

        set_capacity(8);
        random_phase(300, 14);
        set_capacity(16);
        random_phase(360, 40);
        set_capacity(0);
        random_phase(30, 8);
        set_capacity(16);
        random_phase(220, 20);   // count saturation is out of reach here

        req.valid <= 1'b0;
        stim_done = 1;
    end

    // ---------------------------------------------------------------
    // Response side: random stalls, field checks
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        hold_off = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0 || hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            check_beat('{hit: rsp.hit, rdata: rsp.read_value});
        end
    end

    task automatic check_beat(rsp_beat_t got);
        rsp_beat_t want;
        n_rcvd++;
        if (pending_rsp.size() == 0)
        begin
            $error("response beat with nothing expected: hit %0b read_value %h",
                   got.hit, got.rdata);
            errors++;
            return;
        end
        want = pending_rsp.pop_front();
        // typed-in answer must agree with the predictor too
        if (pending_fix.pop_front())
        begin
            rsp_beat_t typed;
            typed = pending_ans.pop_front();
            if (typed != want)
            begin
                $error("directed row answer hit %0b/%h vs predictor %0b/%h",
                       typed.hit, typed.rdata, want.hit, want.rdata);
                errors++;
            end
        end
        else
            void'(pending_ans.pop_front());
        if (got.hit) n_hits++;
        if (got.hit !== want.hit)
        begin
            $error("hit: expected %0b actual %0b", want.hit, got.hit);
            errors++;
        end
        if (got.rdata !== want.rdata)
        begin
            $error("read_value: expected %h actual %h", want.rdata, got.rdata);
            errors++;
        end
    endtask

    // watchdog: cycles with no accepted beat on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
    initial idle_cycles = 0;

    // end of run
    initial
    begin
        wait (stim_done);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
        $display("Sent %0d requests, %0d responses (%0d hits, %0d evictions,",
                 n_sent, n_rcvd, n_hits, n_evict);
        $display("  %0d at capacity zero), capacities 0..31 incl. saturation",
                 n_cap_zero);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/lfu_pkg.sv
src/lfu_req_if.sv
src/lfu_rsp_if.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_table.sv
tb/sv/tb_lfu_cache_table.sv
